[rtl/sjgam_pkg.sv]
// Shared types of the Shift-JIS glyph address mapper.
// Request and response payload structs; no dependencies.
package sjgam_pkg;

   typedef struct packed {
      logic [7:0] lead_byte;
      logic [7:0] trail_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  bytes_used;
      logic        full_width;
      logic [23:0] first_offset;
      logic        second_valid;
      logic [15:0] second_offset;
   } rsp_type;

endpackage

[rtl/sjgam_mapper.sv]
// Combinational glyph offset mapping for one lead/trail byte pair.
// Depends on sjgam_pkg for the payload structs.
module sjgam_mapper (
   input  sjgam_pkg::req_type req,
   output sjgam_pkg::rsp_type rsp
);

   localparam logic [23:0] SPACE_FULL   = 24'h000467;
   localparam logic [23:0] QUESTION     = 24'h000987;
   localparam logic [23:0] SYM_BASE     = 24'h52CD00;
   localparam logic [23:0] GREEK_BASE   = 24'h553D40;
   localparam logic [23:0] KANJI0_BASE  = 24'h56BA01;
   localparam logic [23:0] ROW_MUL      = 24'h002BD4;
   localparam logic [23:0] K1_LO        = 24'h3F70BC;
   localparam logic [23:0] K1_HI        = 24'h3F7161;
   localparam logic [23:0] K2_LO        = 24'h3F8C73;
   localparam logic [23:0] K2_HI        = 24'h3F8D18;
   localparam logic [23:0] K3_LO        = 24'h5DD773;
   localparam logic [23:0] K3_HI        = 24'h5DD818;
   localparam logic [23:0] MUL_SYM      = 24'h0000A4;
   localparam logic [23:0] MUL_KANJI    = 24'h0000A5;

   function automatic logic is_half(input logic [7:0] c);
      return ((c >= 8'h20) && (c <= 8'h7E)) || ((c >= 8'hA1) && (c <= 8'hDF));
   endfunction

   function automatic logic [15:0] half_offset(input logic [7:0] c);
      logic [15:0] c16;
      c16 = {8'h00, c};
      if (c <= 8'h63) return 16'h0386 + c16 * 16'h007E;
      if (c <= 8'h7E) return 16'h0323 + c16 * 16'h007F;
      return c16 * 16'h0081 - 16'h0EFB;
   endfunction

   function automatic logic [23:0] full_offset(input logic [7:0] h, input logic [7:0] l);
      logic [15:0] code;
      logic [23:0] c24;
      logic [23:0] row;
      logic [23:0] kbase;
      int          adj;
      code  = {h, l};
      c24   = {8'h00, code};
      row   = {16'h0000, h} * ROW_MUL;
      kbase = c24 * MUL_KANJI - row;
      adj   = 0;
      if (code >= 16'h8140 && code <= 16'h83D6) begin
         if      (code <= 16'h817E) adj = 1127;
         else if (code <= 16'h81AC) adj = 963;
         else if (code <= 16'h81BF) adj = -841;
         else if (code <= 16'h81CE) adj = -2153;
         else if (code <= 16'h81E8) adj = -3957;
         else if (code <= 16'h81F7) adj = -5105;
         else if (code == 16'h81FC) adj = -5761;
         else if (code <= 16'h8258) adj = -19209;
         else if (code <= 16'h8279) adj = -20357;
         else if (code <= 16'h829A) adj = -21505;
         else if (code <= 16'h82F1) adj = -22161;
         else if (code <= 16'h837E) adj = -34953;
         else if (code <= 16'h8396) adj = -35117;
         else if (code <= 16'h83B6) adj = -36429;
         else if (code >= 16'h83BF) adj = -37741;
         return c24 * MUL_SYM - SYM_BASE + 24'(adj);
      end
      if (code >= 16'h8440 && code <= 16'h84BE) begin
         if      (code <= 16'h8460) adj = 70992;
         else if (code <= 16'h847E) adj = 68517;
         else if (code <= 16'h8491) adj = 68352;
         else if (code >= 16'h849F) adj = 66207;
         return c24 * MUL_KANJI - GREEK_BASE + 24'(adj);
      end
      if (code >= 16'h8740 && code <= 16'h879E) return QUESTION;
      if (code >= 16'h889F && code <= 16'h88FC) return c24 * MUL_KANJI - KANJI0_BASE;
      if (code >= 16'h8940 && code <= 16'h9872) begin
         if (l <= 8'h7E) return kbase - K1_LO;
         if (l >= 8'h80) return kbase - K1_HI;
         return SPACE_FULL;
      end
      if (code >= 16'h989F && code <= 16'h9FFC) begin
         if (l <= 8'h7E) return kbase - K2_LO;
         if (l >= 8'h80) return kbase - K2_HI;
         return SPACE_FULL;
      end
      if (code >= 16'hE040 && code <= 16'hEAA4) begin
         if (l <= 8'h7E) return kbase - K3_LO;
         if (l >= 8'h80) return kbase - K3_HI;
         return SPACE_FULL;
      end
      return SPACE_FULL;
   endfunction

   logic [7:0] lead;
   logic       trail_half;

   assign lead       = (req.lead_byte < 8'h20) ? 8'h20 : req.lead_byte;
   assign trail_half = is_half(req.trail_byte);

   always_comb begin
      if (is_half(lead)) begin
         rsp.full_width    = 1'b0;
         rsp.first_offset  = {8'h00, half_offset(lead)};
         rsp.bytes_used    = trail_half ? 2'd2 : 2'd1;
         rsp.second_valid  = trail_half;
         rsp.second_offset = trail_half ? half_offset(req.trail_byte) : 16'h0000;
      end else begin
         rsp.full_width    = 1'b1;
         rsp.first_offset  = full_offset(lead, req.trail_byte);
         rsp.bytes_used    = 2'd2;
         rsp.second_valid  = 1'b0;
         rsp.second_offset = 16'h0000;
      end
   end

endmodule

[rtl/sjis_glyph_address_mapper_unit.sv]
// Shift-JIS glyph address mapper, top level: input register, mapping, result register.
// A transfer passes through the input register and then the result register before its response is valid.
// Throughput: one transfer per cycle while rsp_ready stays high; the mapping is a single pass between the registers.
// Reset (synchronous, active high) empties both register stages.
// Depends on sjgam_pkg and sjgam_mapper.
module sjis_glyph_address_mapper_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sjgam_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sjgam_pkg::rsp_type rsp_data
);

   logic               s1_valid_ff;
   logic               s1_valid_in;
   sjgam_pkg::req_type s1_data_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   sjgam_pkg::rsp_type rsp_data_ff;
   sjgam_pkg::rsp_type map_rsp;
   logic               rsp_load;
   logic               s1_move;
   logic               req_xfer;

   assign rsp_load  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && rsp_load;
   assign req_ready = !s1_valid_ff || rsp_load;
   assign req_xfer  = req_valid && req_ready;

   assign s1_valid_in  = req_xfer ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = rsp_load ? s1_valid_ff : rsp_valid_ff;

   sjgam_mapper u_mapper (
      .req (s1_data_ff),
      .rsp (map_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_data_ff <= req_data;
      end
      if (s1_move) begin
         rsp_data_ff <= map_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

   a_bytes_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.bytes_used == 2'd1 || rsp_data.bytes_used == 2'd2))
      else $error("bytes_used out of range");

   a_full_no_second: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.full_width) |->
         (!rsp_data.second_valid && rsp_data.second_offset == 16'h0000 &&
          rsp_data.bytes_used == 2'd2))
      else $error("full-width response carries a second glyph");

   a_single_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bytes_used == 2'd1) |->
         (!rsp_data.second_valid && rsp_data.second_offset == 16'h0000))
      else $error("one-byte response carries a second glyph");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_load) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("input stage dropped a stalled item");
`endif

endmodule

[bench/sjgam_checker.sv]
// Response checker for the Shift-JIS glyph address mapper: predicts each transfer's glyph offsets
// and compares them, field by field, with the responses in order.
// Depends on sjgam_pkg; instantiated by tb beside the unit.
`timescale 1ns / 100ps

module sjgam_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  sjgam_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  sjgam_pkg::rsp_type rsp_data,
   output int                 error_count,
   output int                 outstanding
);

   localparam logic [31:0] FULL_SPACE   = 32'h0000_0467;
   localparam logic [31:0] QUERY_GLYPH  = 32'h0000_0987;
   localparam logic [31:0] ROW_STRIDE   = 32'h0000_2BD4;

   sjgam_pkg::rsp_type expected_glyphs [$];

   function automatic logic is_half_width(input logic [7:0] c);
      return (c >= 8'h20 && c <= 8'h7E) || (c >= 8'hA1 && c <= 8'hDF);
   endfunction

   function automatic logic [31:0] half_glyph_offset(input logic [7:0] c);
      logic [31:0] wide;
      wide = {24'h0, c};
      if (c <= 8'h63) return 32'h386 + wide * 32'h7E;
      if (c <= 8'h7E) return 32'h323 + wide * 32'h7F;
      return wide * 32'h81 - 32'hEFB;
   endfunction

   function automatic logic [31:0] full_glyph_offset(input logic [7:0] hi, input logic [7:0] lo);
      logic [31:0] code;
      logic [31:0] adj;
      logic [31:0] row_base;
      logic [31:0] near_bias;
      logic [31:0] far_bias;
      logic        kanji;
      code = {16'h0, hi, lo};
      adj = 32'h0;
      kanji = 1'b0;
      near_bias = 32'h0;
      far_bias = 32'h0;
      row_base = code * 32'hA5 - {24'h0, hi} * ROW_STRIDE;
      if (code >= 32'h8140 && code <= 32'h83D6) begin
         if      (code <= 32'h817E) adj = 32'sd1127;
         else if (code <= 32'h81AC) adj = 32'sd963;
         else if (code <= 32'h81BF) adj = -32'sd841;
         else if (code <= 32'h81CE) adj = -32'sd2153;
         else if (code <= 32'h81E8) adj = -32'sd3957;
         else if (code <= 32'h81F7) adj = -32'sd5105;
         else if (code == 32'h81FC) adj = -32'sd5761;
         else if (code <= 32'h8258) adj = -32'sd19209;
         else if (code <= 32'h8279) adj = -32'sd20357;
         else if (code <= 32'h829A) adj = -32'sd21505;
         else if (code <= 32'h82F1) adj = -32'sd22161;
         else if (code <= 32'h837E) adj = -32'sd34953;
         else if (code <= 32'h8396) adj = -32'sd35117;
         else if (code <= 32'h83B6) adj = -32'sd36429;
         else if (code >= 32'h83BF) adj = -32'sd37741;
         return code * 32'hA4 - 32'h0052_CD00 + adj;
      end
      if (code >= 32'h8440 && code <= 32'h84BE) begin
         if      (code <= 32'h8460) adj = 32'sd70992;
         else if (code <= 32'h847E) adj = 32'sd68517;
         else if (code <= 32'h8491) adj = 32'sd68352;
         else if (code >= 32'h849F) adj = 32'sd66207;
         return code * 32'hA5 - 32'h0055_3D40 + adj;
      end
      if (code >= 32'h8740 && code <= 32'h879E) return QUERY_GLYPH;
      if (code >= 32'h889F && code <= 32'h88FC) return code * 32'hA5 - 32'h0056_BA01;
      if (code >= 32'h8940 && code <= 32'h9872) begin
         kanji = 1'b1;
         near_bias = 32'h003F_70BC;
         far_bias = 32'h003F_7161;
      end else if (code >= 32'h989F && code <= 32'h9FFC) begin
         kanji = 1'b1;
         near_bias = 32'h003F_8C73;
         far_bias = 32'h003F_8D18;
      end else if (code >= 32'hE040 && code <= 32'hEAA4) begin
         kanji = 1'b1;
         near_bias = 32'h005D_D773;
         far_bias = 32'h005D_D818;
      end
      if (!kanji || lo == 8'h7F) return FULL_SPACE;
      return row_base - ((lo < 8'h80) ? near_bias : far_bias);
   endfunction

   function automatic sjgam_pkg::rsp_type map_glyph(input sjgam_pkg::req_type item);
      sjgam_pkg::rsp_type r;
      logic [7:0]         hi;
      logic [31:0]        first;
      logic [31:0]        second;
      r = '0;
      hi = (item.lead_byte < 8'h20) ? 8'h20 : item.lead_byte;
      if (is_half_width(hi)) begin
         first = half_glyph_offset(hi);
         r.bytes_used = 2'd1;
         r.first_offset = first[23:0];
         if (is_half_width(item.trail_byte)) begin
            second = half_glyph_offset(item.trail_byte);
            r.bytes_used = 2'd2;
            r.second_valid = 1'b1;
            r.second_offset = second[15:0];
         end
      end else begin
         first = full_glyph_offset(hi, item.trail_byte);
         r.bytes_used = 2'd2;
         r.full_width = 1'b1;
         r.first_offset = first[23:0];
      end
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, field, want, got);
         error_count++;
      end
   endtask

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin : watch
      sjgam_pkg::rsp_type want;
      if (reset) begin
         expected_glyphs.delete();
      end else begin
         if (req_valid && req_ready) expected_glyphs.push_back(map_glyph(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_glyphs.size() == 0) begin
               $display("%0t: response with none expected, expected nothing, got %h",
                        $time, rsp_data);
               error_count++;
            end else begin
               want = expected_glyphs.pop_front();
               compare_field("bytes_used", 32'(want.bytes_used), 32'(rsp_data.bytes_used));
               compare_field("full_width", 32'(want.full_width), 32'(rsp_data.full_width));
               compare_field("first_offset", 32'(want.first_offset),
                             32'(rsp_data.first_offset));
               compare_field("second_valid", 32'(want.second_valid),
                             32'(rsp_data.second_valid));
               compare_field("second_offset", 32'(want.second_offset),
                             32'(rsp_data.second_offset));
            end
         end
      end
      outstanding <= expected_glyphs.size();
   end

endmodule

[bench/tb.sv]
// Testbench top for sjis_glyph_address_mapper_unit: directed and random character lookups,
// bursty sender, stalling receiver with one long hold-off, and the verdict.
// Depends on sjgam_pkg, sjgam_checker and the unit itself.
`timescale 1ns / 100ps

module tb;

   localparam int CORNER_COUNT = 25;
   localparam int RANDOM_COUNT = 1750;
   localparam int HOLD_START   = 200;
   localparam int HOLD_CYCLES  = 80;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   sjgam_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   sjgam_pkg::rsp_type rsp_data;
   int                 error_count;
   int                 outstanding;

   logic [15:0] corner_codes [0:CORNER_COUNT-1];

   sjis_glyph_address_mapper_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   sjgam_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic sjgam_pkg::req_type random_request();
      sjgam_pkg::req_type item;
      item.trail_byte = 8'($urandom);
      case ($urandom_range(0, 9))
         0, 1, 2: item.lead_byte = 8'($urandom);
         3, 4: begin
            item.lead_byte = $urandom_range(0, 1) ? 8'($urandom_range(8'h20, 8'h7E))
                                                  : 8'($urandom_range(8'hA1, 8'hDF));
         end
         5, 6, 7: begin
            item.lead_byte = $urandom_range(0, 3) ? 8'($urandom_range(8'h81, 8'h9F))
                                                  : 8'($urandom_range(8'hE0, 8'hEA));
            item.trail_byte = 8'($urandom_range(8'h40, 8'hFC));
         end
         default: begin
            item.lead_byte = 8'($urandom_range(8'h81, 8'h88));
            item.trail_byte = 8'($urandom_range(8'h40, 8'hFC));
         end
      endcase
      return item;
   endfunction

   // stimulus: bursts of transfers separated by random gaps
   initial begin
      int                 burst_left;
      int                 gap;
      sjgam_pkg::req_type item;
      corner_codes = '{16'h0041, 16'h1F00, 16'h207E, 16'h6364, 16'h64A1,
                       16'h7EDF, 16'hA1DF, 16'hDFE0, 16'h7F40, 16'hA0FF,
                       16'h8140, 16'h81FC, 16'h81F8, 16'h83B7, 16'h8440,
                       16'h8492, 16'h84BE, 16'h8740, 16'h889F, 16'h897F,
                       16'h989F, 16'h9FFC, 16'hE040, 16'hEAA4, 16'hFFFF};
      burst_left = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int n = 0; n < CORNER_COUNT + RANDOM_COUNT; n++) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
         end
         if (n < CORNER_COUNT) item = corner_codes[n];
         else item = random_request();
         req_data <= item;
         req_valid <= 1'b1;
         do @(posedge clock); while (!req_ready);
         burst_left--;
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // receiver: phases of varying readiness, one long hold-off
   initial begin
      int cycle_no;
      int phase_left;
      int ready_pct;
      cycle_no = 0;
      phase_left = 0;
      ready_pct = 100;
      forever begin
         @(posedge clock);
         cycle_no++;
         if (cycle_no == HOLD_START) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            cycle_no += HOLD_CYCLES;
         end else begin
            if (phase_left == 0) begin
               phase_left = $urandom_range(5, 40);
               case ($urandom_range(0, 3))
                  0: ready_pct = 100;
                  1: ready_pct = 70;
                  2: ready_pct = 40;
                  default: ready_pct = 10;
               endcase
            end
            phase_left--;
            rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

endmodule

[files.f]
rtl/sjgam_pkg.sv
rtl/sjgam_mapper.sv
rtl/sjis_glyph_address_mapper_unit.sv
bench/sjgam_checker.sv
bench/tb.sv
